>>> rtl/core/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg: shared types and constants of the unique value set table
// Request codes, result status codes, sequencer states and the result word
// passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package uvst_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int VALUE_W = 31;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [KIND_W-1:0] REQ_SEARCH = 2'd0;
	localparam logic [KIND_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] REQ_DELETE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  entry_count;
	} res_t;

endpackage

>>> rtl/core/uvst_mem.sv
// ----------------------------------------------------------------------------
// uvst_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uvst_mem #(
	parameter int DEPTH = uvst_pkg::CAPACITY_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [IDX_W-1:0]             waddr,
	input  logic [uvst_pkg::VALUE_W-1:0] wdata,
	input  logic [IDX_W-1:0]             raddr,
	output logic [uvst_pkg::VALUE_W-1:0] rdata
);

	logic [uvst_pkg::VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/uvst_seq.sv
// ----------------------------------------------------------------------------
// uvst_seq: request sequencer
// Walks the entry memory one position a cycle with a single comparator,
// appends new values and closes the gap left by a delete.
// ----------------------------------------------------------------------------
module uvst_seq #(
	parameter int CAPACITY = uvst_pkg::CAPACITY_DEF,
	parameter int IDX_W = $clog2(CAPACITY),
	parameter int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [uvst_pkg::KIND_W-1:0]  req_type,
	input  logic [uvst_pkg::VALUE_W-1:0] value,
	output logic                         res_valid,
	input  logic                         res_take,
	output uvst_pkg::res_t               res,
	output logic                         mem_we,
	output logic [IDX_W-1:0]             mem_waddr,
	output logic [uvst_pkg::VALUE_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]             mem_raddr,
	input  logic [uvst_pkg::VALUE_W-1:0] mem_rdata
);

	uvst_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic cmp_vld_q, cmp_vld_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic [uvst_pkg::KIND_W-1:0] kind_q, kind_d;
	logic [uvst_pkg::VALUE_W-1:0] val_q, val_d;
	uvst_pkg::status_t status_q, status_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvst_pkg::S_IDLE;
			count_q <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		cmp_idx_q <= cmp_idx_d;
		kind_q <= kind_d;
		val_q <= val_d;
		status_q <= status_d;
		pos_q <= pos_d;
	end

	// The word read last cycle is compared against the request value.
	assign hit = cmp_vld_q && (mem_rdata == val_q);

	assign req_stall = (state_q != uvst_pkg::S_IDLE);
	assign res_valid = (state_q == uvst_pkg::S_DONE);
	assign res.status = status_q;
	assign res.position = uvst_pkg::POS_W'(pos_q);
	assign res.entry_count = uvst_pkg::COUNT_W'(count_q);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		kind_d = kind_q;
		val_d = val_q;
		status_d = status_q;
		pos_d = pos_q;
		mem_we = 1'b0;
		mem_waddr = cmp_idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[IDX_W-1:0];

		unique case (state_q)
			uvst_pkg::S_IDLE: begin
				if (req_valid) begin
					kind_d = req_type;
					val_d = value;
					idx_d = '0;
					cmp_vld_d = 1'b0;
					pos_d = '0;
					case (req_type) inside
						uvst_pkg::REQ_SEARCH, uvst_pkg::REQ_DELETE: begin
							if (count_q == '0) begin
								status_d = uvst_pkg::ST_EMPTY;
								state_d = uvst_pkg::S_DONE;
							end else begin
								state_d = uvst_pkg::S_SCAN;
							end
						end
						uvst_pkg::REQ_INSERT: begin
							if (count_q == '0) begin
								state_d = uvst_pkg::S_APPEND;
							end else begin
								state_d = uvst_pkg::S_SCAN;
							end
						end
						default: begin
							status_d = uvst_pkg::ST_NOT_FOUND;
							state_d = uvst_pkg::S_DONE;
						end
					endcase
				end
			end

			uvst_pkg::S_SCAN: begin
				// Issue the next read while the previous word is compared.
				if (idx_q < count_q) begin
					idx_d = idx_q + CNT_W'(1);
					cmp_vld_d = 1'b1;
					cmp_idx_d = idx_q[IDX_W-1:0];
				end else begin
					cmp_vld_d = 1'b0;
				end

				if (hit) begin
					case (kind_q)
						uvst_pkg::REQ_SEARCH: begin
							status_d = uvst_pkg::ST_OK;
							pos_d = cmp_idx_q;
							state_d = uvst_pkg::S_DONE;
						end
						uvst_pkg::REQ_INSERT: begin
							status_d = uvst_pkg::ST_DUPLICATE;
							state_d = uvst_pkg::S_DONE;
						end
						default: begin
							pos_d = cmp_idx_q;
							idx_d = CNT_W'(cmp_idx_q) + CNT_W'(1);
							cmp_vld_d = 1'b0;
							state_d = uvst_pkg::S_SHIFT;
						end
					endcase
				end else if (!cmp_vld_q && (idx_q == count_q)) begin
					if (kind_q == uvst_pkg::REQ_INSERT) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							status_d = uvst_pkg::ST_FULL;
							state_d = uvst_pkg::S_DONE;
						end else begin
							state_d = uvst_pkg::S_APPEND;
						end
					end else begin
						status_d = uvst_pkg::ST_NOT_FOUND;
						state_d = uvst_pkg::S_DONE;
					end
				end
			end

			uvst_pkg::S_APPEND: begin
				mem_we = 1'b1;
				mem_waddr = count_q[IDX_W-1:0];
				mem_wdata = val_q;
				pos_d = count_q[IDX_W-1:0];
				count_d = count_q + CNT_W'(1);
				status_d = uvst_pkg::ST_OK;
				state_d = uvst_pkg::S_DONE;
			end

			uvst_pkg::S_SHIFT: begin
				// Each word read one cycle is written one position lower the next.
				mem_we = cmp_vld_q;
				if (idx_q < count_q) begin
					idx_d = idx_q + CNT_W'(1);
					cmp_vld_d = 1'b1;
					cmp_idx_d = idx_q[IDX_W-1:0] - IDX_W'(1);
				end else begin
					cmp_vld_d = 1'b0;
					if (!cmp_vld_q) begin
						count_d = count_q - CNT_W'(1);
						status_d = uvst_pkg::ST_OK;
						state_d = uvst_pkg::S_DONE;
					end
				end
			end

			uvst_pkg::S_DONE: begin
				if (res_take) begin
					state_d = uvst_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = uvst_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/unique_value_set_table.sv
// ----------------------------------------------------------------------------
// unique_value_set_table: table of distinct 31-bit values
// Search, insert and delete requests over a compact table of values.
// ----------------------------------------------------------------------------
// A request word (req_type, value) is taken when req_valid is high and
// req_stall is low. req_type 0 searches, 1 inserts, 2 deletes. Each request
// gives one result word (status, position, entry_count) on the rsp channel,
// taken when rsp_valid is high and rsp_stall is low.
// The entries live in a memory with one read and one write port, and one
// sequencer walks it one position per cycle, so the memory port sets the
// rate. A search or a delete scans the stored entries until a match or the
// end; an insert scans for a duplicate and then appends if there is room,
// and a delete that matches then shifts the later entries down. A request on
// an empty table or with an unused code skips the scan, as does an insert
// into an empty table. The result word enters the output register at the
// same edge at which the input becomes free again.
// req_stall is high from acceptance until the result moves into the output
// register. A stalled result holds in the output register while the next
// request is already taken and worked on. Reset empties the table at once;
// no clearing pass is needed since only stored positions are ever read.
// ----------------------------------------------------------------------------
module unique_value_set_table #(
	parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [uvst_pkg::KIND_W-1:0]    req_type,
	input  logic [uvst_pkg::VALUE_W-1:0]   value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [uvst_pkg::STATUS_W-1:0]  status,
	output logic [uvst_pkg::POS_W-1:0]     position,
	output logic [uvst_pkg::COUNT_W-1:0]   entry_count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [uvst_pkg::VALUE_W-1:0] mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	logic [uvst_pkg::VALUE_W-1:0] mem_rdata;

	logic           res_valid;
	logic           res_take;
	uvst_pkg::res_t res;

	logic           rsp_vld_q;
	uvst_pkg::res_t rsp_q;

	uvst_mem #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	uvst_seq #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.value     (value),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// The output register takes a new word when it is empty or being drained.
	assign res_take = res_valid && (!rsp_vld_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_take) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign status = rsp_q.status;
	assign position = rsp_q.position;
	assign entry_count = rsp_q.entry_count;

endmodule

>>> tb/uvst_checker.sv
// ----------------------------------------------------------------------------
// uvst_checker: scoreboard for the unique value set table
// Watches the request and response channels and keeps its own copy of the
// table. Each accepted request yields one expected result word, and each
// accepted response word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module uvst_checker #(
	parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  logic [uvst_pkg::KIND_W-1:0]    req_type,
	input  logic [uvst_pkg::VALUE_W-1:0]   value,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  logic [uvst_pkg::STATUS_W-1:0]  status,
	input  logic [uvst_pkg::POS_W-1:0]     position,
	input  logic [uvst_pkg::COUNT_W-1:0]   entry_count,
	output int                             errors,
	output int                             pending,
	output int                             n_req,
	output int                             n_rsp,
	output int                             n_full,
	output int                             n_dup,
	output int                             n_empty
);
	import uvst_pkg::*;

	logic [VALUE_W-1:0] slots [CAPACITY];
	int used;
	res_t answers_due [$];
	int err_cnt, req_cnt, rsp_cnt, full_cnt, dup_cnt, empty_cnt;

	// Applies one request to the local copy of the table and returns the
	// result word that the block should give for it.
	function automatic res_t table_apply(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] v);
		res_t r;
		int hit;
		int i;
		hit = -1;
		for (i = 0; i < used; i++) begin
			if (hit < 0 && slots[i] == v) hit = i;
		end
		r.status = ST_NOT_FOUND;
		r.position = '0;
		case (kind)
			REQ_SEARCH: begin
				if (used == 0) begin
					r.status = ST_EMPTY;
				end else if (hit >= 0) begin
					r.status = ST_OK;
					r.position = POS_W'(hit);
				end
			end
			REQ_INSERT: begin
				// A duplicate is reported even when the table is full.
				if (hit >= 0) begin
					r.status = ST_DUPLICATE;
				end else if (used >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slots[used] = v;
					r.status = ST_OK;
					r.position = POS_W'(used);
					used++;
				end
			end
			REQ_DELETE: begin
				if (used == 0) begin
					r.status = ST_EMPTY;
				end else if (hit >= 0) begin
					for (i = hit; i < used - 1; i++) slots[i] = slots[i + 1];
					used--;
					r.status = ST_OK;
					r.position = POS_W'(hit);
				end
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_W'(used);
		return r;
	endfunction

	task automatic match(string field, logic [6:0] want_v, logic [6:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			used = 0;
			answers_due.delete();
			err_cnt = 0;
			req_cnt = 0;
			rsp_cnt = 0;
			full_cnt = 0;
			dup_cnt = 0;
			empty_cnt = 0;
			errors <= 0;
			pending <= 0;
			n_req <= 0;
			n_rsp <= 0;
			n_full <= 0;
			n_dup <= 0;
			n_empty <= 0;
		end else begin
			// The response taken at this edge always belongs to an earlier
			// request, so it is checked before the new request is predicted.
			if (rsp_valid && !rsp_stall) begin
				rsp_cnt++;
				if (answers_due.size() == 0) begin
					$display("%0t: result word with none expected, actual status %0d position %0d count %0d",
						$time, status, position, entry_count);
					err_cnt++;
				end else begin
					want = answers_due.pop_front();
					match("status", 7'(want.status), 7'(status));
					match("position", 7'(want.position), 7'(position));
					match("entry_count", want.entry_count, entry_count);
				end
			end
			if (req_valid && !req_stall) begin
				want = table_apply(req_type, value);
				answers_due.push_back(want);
				req_cnt++;
				if (want.status == ST_FULL) full_cnt++;
				if (want.status == ST_DUPLICATE) dup_cnt++;
				if (want.status == ST_EMPTY) empty_cnt++;
			end
			errors <= err_cnt;
			pending <= answers_due.size();
			n_req <= req_cnt;
			n_rsp <= rsp_cnt;
			n_full <= full_cnt;
			n_dup <= dup_cnt;
			n_empty <= empty_cnt;
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the unique value set table
// A short directed sequence covers the empty, duplicate and no-op cases, then
// rounds of fill, full, drain and mixed traffic run with random gaps on both
// channels. The checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import uvst_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int POOL_N = 80;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int TARGET_ITEMS = 1000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [KIND_W-1:0] req_type;
	logic [VALUE_W-1:0] value;
	logic rsp_valid;
	logic rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0] position;
	logic [COUNT_W-1:0] entry_count;

	int errors, pending, n_req, n_rsp, n_full, n_dup, n_empty;
	int sent;
	int idle_cycles;
	logic [VALUE_W-1:0] pool [POOL_N];
	bit calm;

	unique_value_set_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position),
		.entry_count(entry_count)
	);

	uvst_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position),
		.entry_count(entry_count),
		.errors(errors),
		.pending(pending),
		.n_req(n_req),
		.n_rsp(n_rsp),
		.n_full(n_full),
		.n_dup(n_dup),
		.n_empty(n_empty)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Mostly short gaps, now and then a long one; none in a calm stretch.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Offers one request word and returns at the edge where it is taken.
	task automatic send(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] v);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		value <= v;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (kind != KIND_UNUSED) sent++;
	endtask

	// Stops offering until every outstanding result word has come back.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic send_mixed(int span);
		int r;
		logic [VALUE_W-1:0] v;
		r = $urandom_range(99);
		v = ($urandom_range(99) < 85) ? pool[$urandom_range(span - 1)] : VALUE_W'($urandom());
		if (r < 35) send(REQ_INSERT, v);
		else if (r < 65) send(REQ_DELETE, v);
		else if (r < 95) send(REQ_SEARCH, v);
		else send(KIND_UNUSED, v);
	endtask

	task automatic run_round();
		int order [POOL_N];
		int i, j, t;
		for (i = 0; i < POOL_N; i++) begin
			pool[i] = VALUE_W'($urandom());
			order[i] = i;
		end
		calm = ($urandom_range(3) == 0);
		// Fill with more distinct values than the table holds.
		for (i = 0; i < POOL_N; i++) begin
			send(REQ_INSERT, pool[i]);
			if ($urandom_range(99) < 30) send(REQ_SEARCH, pool[$urandom_range(i)]);
		end
		// Full table: unstored values hit the full case, stored ones are duplicates.
		for (i = 0; i < 30; i++) begin
			t = $urandom_range(99);
			if (t < 40) send(REQ_INSERT, VALUE_W'($urandom()));
			else if (t < 70) send(REQ_INSERT, pool[$urandom_range(POOL_N - 1)]);
			else send(REQ_SEARCH, pool[$urandom_range(POOL_N - 1)]);
		end
		drain();
		calm = ($urandom_range(3) == 0);
		for (i = POOL_N - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i < POOL_N; i++) begin
			send(REQ_DELETE, pool[order[i]]);
			if ($urandom_range(99) < 25) send(REQ_SEARCH, pool[$urandom_range(POOL_N - 1)]);
		end
		calm = ($urandom_range(3) == 0);
		for (i = 0; i < 120; i++) send_mixed(40);
		drain();
	endtask

	// Receiver: random stalls, and twice a long hold-off so the block backs up.
	initial begin
		int stall_len;
		int hold_idx;
		int calm_left;
		int hold_at [2];
		hold_at[0] = 80;
		hold_at[1] = 600;
		hold_idx = 0;
		calm_left = 0;
		rsp_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_idx < 2 && n_req >= hold_at[hold_idx]) begin
				hold_idx++;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (calm_left == 0 && $urandom_range(29) == 0) calm_left = 40;
			if (calm_left > 0) calm_left--;
			stall_len = pick_gap(calm_left > 0);
			if (stall_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("[unique_value_set_table] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sent = 0;
		calm = 1'b0;
		req_valid <= 1'b0;
		req_type <= REQ_SEARCH;
		value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes of the value, duplicates, no-op code,
		// first, middle and last positions, and emptying the table again.
		send(REQ_SEARCH, 31'd5);
		send(REQ_DELETE, 31'd5);
		send(KIND_UNUSED, 31'h7FFFFFFF);
		send(REQ_INSERT, 31'd0);
		send(REQ_INSERT, 31'h7FFFFFFF);
		send(REQ_INSERT, 31'd0);
		send(REQ_SEARCH, 31'h7FFFFFFF);
		send(REQ_SEARCH, 31'd0);
		send(REQ_SEARCH, 31'h2AAAAAAA);
		send(REQ_DELETE, 31'h55555555);
		send(KIND_UNUSED, 31'h55555555);
		send(REQ_INSERT, 31'h2AAAAAAA);
		send(REQ_INSERT, 31'h55555555);
		send(REQ_DELETE, 31'd0);
		send(REQ_SEARCH, 31'h55555555);
		send(REQ_DELETE, 31'h55555555);
		send(REQ_DELETE, 31'h7FFFFFFF);
		send(REQ_DELETE, 31'h2AAAAAAA);
		send(REQ_SEARCH, 31'd0);
		send(REQ_DELETE, 31'h2AAAAAAA);
		drain();

		while (sent < TARGET_ITEMS) run_round();

		drain();
		repeat (200) @(posedge clk);
		$display("Run covered %0d requests and %0d result words.", n_req, n_rsp);
		$display("Full table rejects: %0d, duplicates: %0d, empty table cases: %0d.",
			n_full, n_dup, n_empty);
		if (errors == 0 && pending == 0) begin
			$display("[unique_value_set_table] OK");
		end else begin
			$display("[unique_value_set_table] ERROR");
		end
		$finish;
	end

endmodule
